// ===== hdl/nfsa_pkg.sv =====
// Shared constants, codes and types of the next-fit slot allocator.
package nfsa_pkg;

   localparam int MAX_SLOTS_DEF = 256;   // default size of the slot map
   localparam int SLOT_LIMIT    = 256;   // slots reachable by an 8-bit index
   localparam int WORD_W        = 32;    // map bits per memory word
   localparam int WORD_BITS     = 5;     // log2 of WORD_W
   localparam int IDX_W         = 8;     // slot index width
   localparam int CNT_W         = 9;     // slot count width

   localparam logic MODE_ALLOC   = 1'b0;
   localparam logic MODE_RELEASE = 1'b1;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_RANGE    = 2'd2;
   localparam logic [1:0] ST_NOT_USED = 2'd3;

   localparam logic REG_SLOT_COUNT = 1'b0;

   typedef struct packed {
      logic                 free_hit;
      logic [WORD_BITS-1:0] free_pos;
      logic                 used_hit;
      logic [WORD_BITS-1:0] used_pos;
   } eval_type;

endpackage

// ===== hdl/next_fit_slot_allocator.sv =====
// Next-fit slot allocator: word-wide used map in memory, hint register and APB register port.
//
// A request is taken when start is high and busy is low; its result shows on the rsp_ ports
// for exactly one cycle, marked by rsp_strobe, and cannot be held off. The used map sits in a
// single-port memory of 32-bit words with a registered read, and every word visited passes
// through a read state and an evaluate state. An allocate visits words from the one that holds
// the hint up to the count and then, if needed, from word 0 below the hint; a request that
// fails its range check or meets a zero count is answered from idle. A release reads and
// checks the slot's word, which is all a release of a free slot takes; a slot that is freed
// then costs a read and an evaluate for each word the hint walk reads, at least the word that
// holds the hint. The next request may start in the cycle its predecessor's result is shown. The
// map reads as all free after reset with no clearing pass, since every word carries a valid
// flag.
module next_fit_slot_allocator #(
   parameter int MAX_SLOTS = nfsa_pkg::MAX_SLOTS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_mode,
   input  logic [nfsa_pkg::IDX_W-1:0]     req_slot_index,
   output logic                           rsp_strobe,
   output logic [1:0]                     rsp_status,
   output logic [nfsa_pkg::IDX_W-1:0]     rsp_slot_index_res,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [2:0]                     paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);

   localparam int NSLOTS = (MAX_SLOTS < nfsa_pkg::SLOT_LIMIT) ? MAX_SLOTS
                                                               : nfsa_pkg::SLOT_LIMIT;
   localparam int WORDS  = (NSLOTS + nfsa_pkg::WORD_W - 1) / nfsa_pkg::WORD_W;
   localparam int WA     = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int CW     = nfsa_pkg::CNT_W;
   localparam int BW     = nfsa_pkg::WORD_BITS;

   localparam logic REG_SLOT_COUNT_IDX = nfsa_pkg::REG_SLOT_COUNT;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_ARD  = 3'd1;
   localparam logic [2:0] S_AEV  = 3'd2;
   localparam logic [2:0] S_RRD  = 3'd3;
   localparam logic [2:0] S_REV  = 3'd4;
   localparam logic [2:0] S_WRD  = 3'd5;
   localparam logic [2:0] S_WEV  = 3'd6;

   logic [CW-1:0]                 slot_count_ff;
   logic [2:0]                    state_ff, state_in;
   logic [WA-1:0]                 addr_ff, addr_in;
   logic [CW-1:0]                 lo_ff, lo_in;
   logic [CW-1:0]                 hi_ff, hi_in;
   logic [BW-1:0]                 top_ff, top_in;
   logic                          wrap_ff, wrap_in;
   logic [nfsa_pkg::IDX_W-1:0]    hint_ff, hint_in;
   logic [nfsa_pkg::IDX_W-1:0]    idx_ff, idx_in;
   logic                          rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]                    rsp_status_ff, rsp_status_in;
   logic [nfsa_pkg::IDX_W-1:0]    rsp_slot_ff, rsp_slot_in;

   logic [nfsa_pkg::WORD_W-1:0]   map_mem [WORDS];
   logic [nfsa_pkg::WORD_W-1:0]   rd_data_ff;
   logic                          rd_vld_ff;
   logic                          word_valid_ff [WORDS];
   logic                          mem_re, mem_we;
   logic [nfsa_pkg::WORD_W-1:0]   mem_wdata;
   logic [nfsa_pkg::WORD_W-1:0]   word_data;

   logic [CW-1:0]                 count_eff;
   logic [nfsa_pkg::IDX_W-1:0]    hint_norm;
   logic                          accept;
   logic                          cfg_write;
   nfsa_pkg::eval_type            eval;

   assign count_eff = (slot_count_ff > CW'(NSLOTS)) ? CW'(NSLOTS) : slot_count_ff;
   assign hint_norm = ({1'b0, hint_ff} >= count_eff) ? '0 : hint_ff;
   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE);
   assign cfg_write = psel && penable && pwrite && pready;

   // Register port.
   assign pready = 1'b1;
   always_comb begin
      unique case (paddr[2])
         REG_SLOT_COUNT_IDX: prdata = {{(32 - CW){1'b0}}, slot_count_ff};
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= CW'(256);
      end else if (cfg_write && paddr[2] == REG_SLOT_COUNT_IDX) begin
         slot_count_ff <= pwdata[CW-1:0];
      end
   end

   // Map memory; a word never written reads as all free.
   assign mem_re    = (state_ff == S_ARD) || (state_ff == S_RRD) || (state_ff == S_WRD);
   assign word_data = rd_vld_ff ? rd_data_ff : '0;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[addr_ff] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= map_mem[addr_ff];
         rd_vld_ff  <= word_valid_ff[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < WORDS; w++) begin
            word_valid_ff[w] <= 1'b0;
         end
      end else if (mem_we) begin
         word_valid_ff[addr_ff] <= 1'b1;
      end
   end

   nfsa_word_eval #(
      .ADDR_W (WA)
   ) u_eval (
      .word_data (word_data),
      .word_addr (addr_ff),
      .lo        (lo_ff),
      .hi        (hi_ff),
      .top       (top_ff),
      .result    (eval)
   );

   // Sequencer.
   always_comb begin
      logic [CW-1:0] hit_slot;
      logic [CW-1:0] hit_next;
      logic [CW-1:0] run_start;
      logic [WA-1:0] last_addr;

      state_in      = state_ff;
      addr_in       = addr_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      top_in        = top_ff;
      wrap_in       = wrap_ff;
      hint_in       = hint_ff;
      idx_in        = idx_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      mem_we        = 1'b0;
      mem_wdata     = word_data;

      hit_slot  = CW'({addr_ff, eval.free_pos});
      hit_next  = hit_slot + CW'(1);
      run_start = CW'({addr_ff, eval.used_pos}) + CW'(1);
      last_addr = WA'((hi_ff - CW'(1)) >> BW);

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               hint_in = hint_norm;
               idx_in  = req_slot_index;
               if (req_mode == nfsa_pkg::MODE_ALLOC) begin
                  if (count_eff == '0) begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = nfsa_pkg::ST_FULL;
                     rsp_slot_in   = '0;
                  end else begin
                     // First pass covers hint up to the count, the wrap pass below the hint.
                     lo_in    = CW'(hint_norm);
                     hi_in    = count_eff;
                     wrap_in  = 1'b0;
                     addr_in  = WA'(hint_norm >> BW);
                     state_in = S_ARD;
                  end
               end else begin
                  if ({1'b0, req_slot_index} >= count_eff) begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = nfsa_pkg::ST_RANGE;
                     rsp_slot_in   = '0;
                  end else begin
                     addr_in  = WA'(req_slot_index >> BW);
                     state_in = S_RRD;
                  end
               end
            end
         end
         S_ARD: begin
            state_in = S_AEV;
         end
         S_AEV: begin
            if (eval.free_hit) begin
               mem_we                  = 1'b1;
               mem_wdata[eval.free_pos] = 1'b1;
               hint_in       = (hit_next < count_eff) ? hit_next[nfsa_pkg::IDX_W-1:0] : '0;
               rsp_strobe_in = 1'b1;
               rsp_status_in = nfsa_pkg::ST_OK;
               rsp_slot_in   = hit_slot[nfsa_pkg::IDX_W-1:0];
               state_in      = S_IDLE;
            end else if (addr_ff == last_addr) begin
               if (!wrap_ff && hint_ff != '0) begin
                  lo_in    = '0;
                  hi_in    = CW'(hint_ff);
                  wrap_in  = 1'b1;
                  addr_in  = '0;
                  state_in = S_ARD;
               end else begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = nfsa_pkg::ST_FULL;
                  rsp_slot_in   = '0;
                  state_in      = S_IDLE;
               end
            end else begin
               addr_in  = addr_ff + WA'(1);
               state_in = S_ARD;
            end
         end
         S_RRD: begin
            state_in = S_REV;
         end
         S_REV: begin
            if (!word_data[idx_ff[BW-1:0]]) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = nfsa_pkg::ST_NOT_USED;
               rsp_slot_in   = '0;
               state_in      = S_IDLE;
            end else begin
               // The freed word is written here; the walk then reads from the word that holds the hint.
               mem_we                    = 1'b1;
               mem_wdata[idx_ff[BW-1:0]] = 1'b0;
               addr_in  = WA'(hint_ff >> BW);
               top_in   = hint_ff[BW-1:0];
               state_in = S_WRD;
            end
         end
         S_WRD: begin
            state_in = S_WEV;
         end
         S_WEV: begin
            if (eval.used_hit) begin
               // A used bit right at the top leaves the hint where it is.
               if (eval.used_pos != top_ff) begin
                  hint_in = run_start[nfsa_pkg::IDX_W-1:0];
               end
               rsp_strobe_in = 1'b1;
               rsp_status_in = nfsa_pkg::ST_OK;
               rsp_slot_in   = '0;
               state_in      = S_IDLE;
            end else begin
               hint_in = nfsa_pkg::IDX_W'({addr_ff, {BW{1'b0}}});
               if (addr_ff == '0) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = nfsa_pkg::ST_OK;
                  rsp_slot_in   = '0;
                  state_in      = S_IDLE;
               end else begin
                  addr_in  = addr_ff - WA'(1);
                  top_in   = {BW{1'b1}};
                  state_in = S_WRD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         hint_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hint_ff       <= hint_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      top_ff        <= top_in;
      wrap_ff       <= wrap_in;
      idx_ff        <= idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_slot_index_res = rsp_slot_ff;

endmodule

// ===== hdl/nfsa_word_eval.sv =====
// Evaluation of one map word: lowest free slot in a window and highest used bit at or below a limit.
module nfsa_word_eval #(
   parameter int ADDR_W = 3
) (
   input  logic [nfsa_pkg::WORD_W-1:0]    word_data,
   input  logic [ADDR_W-1:0]              word_addr,
   input  logic [nfsa_pkg::CNT_W-1:0]     lo,
   input  logic [nfsa_pkg::CNT_W-1:0]     hi,
   input  logic [nfsa_pkg::WORD_BITS-1:0] top,
   output nfsa_pkg::eval_type             result
);

   always_comb begin
      logic [nfsa_pkg::CNT_W-1:0] slot;
      result = '0;
      // Descending, so the lowest free slot inside the window wins.
      for (int b = nfsa_pkg::WORD_W - 1; b >= 0; b--) begin
         slot = nfsa_pkg::CNT_W'({word_addr, nfsa_pkg::WORD_BITS'(b)});
         if (!word_data[b] && slot >= lo && slot < hi) begin
            result.free_hit = 1'b1;
            result.free_pos = nfsa_pkg::WORD_BITS'(b);
         end
      end
      // Ascending, so the highest used bit at or below top wins.
      for (int b = 0; b < nfsa_pkg::WORD_W; b++) begin
         if (word_data[b] && nfsa_pkg::WORD_BITS'(b) <= top) begin
            result.used_hit = 1'b1;
            result.used_pos = nfsa_pkg::WORD_BITS'(b);
         end
      end
   end

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench of the next-fit slot allocator with its own used-map predictor.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [1:0]                 status;
      logic [nfsa_pkg::IDX_W-1:0] slot;
   } alloc_result_type;

   // Tracks the used map, the next-fit hint and the slot count, and holds the
   // results still owed by the block in request order.
   class slot_pool_model;
      bit [nfsa_pkg::SLOT_LIMIT-1:0] used_map;
      int                            hint;
      int                            slot_count = 256;
      int                            errors;
      alloc_result_type              owed_results[$];

      function int active_slots();
         return (slot_count > nfsa_pkg::SLOT_LIMIT) ? nfsa_pkg::SLOT_LIMIT : slot_count;
      endfunction

      function void note_request(logic mode, logic [nfsa_pkg::IDX_W-1:0] idx);
         alloc_result_type r;
         int               n;
         int               i;
         bit               found;
         n = active_slots();
         r.status = nfsa_pkg::ST_OK;
         r.slot = '0;
         if (hint >= n) hint = 0;
         if (mode == nfsa_pkg::MODE_ALLOC) begin
            i = hint;
            found = 0;
            for (int k = 0; k < n && !found; k++) begin
               if (!used_map[i]) begin
                  used_map[i] = 1'b1;
                  r.slot = nfsa_pkg::IDX_W'(i);
                  hint = (i + 1 < n) ? i + 1 : 0;
                  found = 1;
               end else begin
                  i = (i + 1 < n) ? i + 1 : 0;
               end
            end
            if (!found) r.status = nfsa_pkg::ST_FULL;
         end else if (idx >= n) begin
            r.status = nfsa_pkg::ST_RANGE;
         end else if (!used_map[idx]) begin
            r.status = nfsa_pkg::ST_NOT_USED;
         end else begin
            used_map[idx] = 1'b0;
            // The hint slides down across the free run that ends at it.
            i = hint + 1;
            while (i > 0 && !used_map[i-1]) begin
               hint = i - 1;
               i--;
            end
         end
         owed_results.push_back(r);
      endfunction

      function void check_result(logic [1:0] status, logic [nfsa_pkg::IDX_W-1:0] slot);
         alloc_result_type r;
         if (owed_results.size() == 0) begin
            $error("result beat with none outstanding: status %0d, slot %0d", status, slot);
            errors++;
            return;
         end
         r = owed_results.pop_front();
         if (status !== r.status) begin
            $error("status mismatch: expected %0d, actual %0d", r.status, status);
            errors++;
         end
         if (slot !== r.slot) begin
            $error("slot_index_res mismatch: expected %0d, actual %0d", r.slot, slot);
            errors++;
         end
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic                       req_mode = nfsa_pkg::MODE_ALLOC;
   logic [nfsa_pkg::IDX_W-1:0] req_slot_index = '0;
   logic                       rsp_strobe;
   logic [1:0]                 rsp_status;
   logic [nfsa_pkg::IDX_W-1:0] rsp_slot_index_res;
   logic                       psel = 1'b0;
   logic                       penable = 1'b0;
   logic                       pwrite = 1'b0;
   logic [2:0]                 paddr = '0;
   logic [31:0]                pwdata = '0;
   logic [31:0]                prdata;
   logic                       pready;

   slot_pool_model pool_model = new;

   next_fit_slot_allocator i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_mode           (req_mode),
      .req_slot_index     (req_slot_index),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_slot_index_res (rsp_slot_index_res),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // A result beat is checked before a request taken on the same edge is noted.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) pool_model.check_result(rsp_status, rsp_slot_index_res);
         if (start && !busy) pool_model.note_request(req_mode, req_slot_index);
      end
   end

   task automatic send_request(input logic mode, input logic [nfsa_pkg::IDX_W-1:0] idx,
                               input int idle_pct);
      int gap;
      gap = 0;
      while (gap < 60 && $urandom_range(0, 99) < idle_pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_mode <= mode;
      req_slot_index <= idx;
      do @(posedge clock); while (busy);
   endtask

   // Leaves the block with nothing outstanding and room for a trailing hint walk.
   task automatic drain();
      start <= 1'b0;
      while (pool_model.owed_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_slot_count(input int value);
      drain();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {nfsa_pkg::REG_SLOT_COUNT, 2'b00};
      pwdata <= 32'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      pool_model.slot_count = value & 'h1FF;
   endtask

   // The first part of a phase leans toward allocation so that the pool fills,
   // the rest leans toward release so that it drains again.
   task automatic run_phase(input int count, input int items, input int idle_pct);
      int                         n;
      logic                       mode;
      logic [nfsa_pkg::IDX_W-1:0] idx;
      write_slot_count(count);
      n = pool_model.active_slots();
      for (int k = 0; k < items; k++) begin
         mode = ($urandom_range(0, 99) < ((k < items * 3 / 4) ? 85 : 25)) ?
                nfsa_pkg::MODE_ALLOC : nfsa_pkg::MODE_RELEASE;
         if (n > 0 && $urandom_range(0, 3) != 0) begin
            idx = nfsa_pkg::IDX_W'($urandom_range(0, n - 1));
         end else begin
            idx = nfsa_pkg::IDX_W'($urandom);
         end
         send_request(mode, idx, idle_pct);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Full pool of 256 slots: releases of free slots at both ends, then a
      // short allocate/release sequence that moves the hint both ways.
      send_request(nfsa_pkg::MODE_RELEASE, 8'd0, 0);
      send_request(nfsa_pkg::MODE_RELEASE, 8'd255, 0);
      repeat (3) send_request(nfsa_pkg::MODE_ALLOC, 8'hFF, 0);
      send_request(nfsa_pkg::MODE_RELEASE, 8'd1, 0);
      send_request(nfsa_pkg::MODE_RELEASE, 8'd2, 0);
      send_request(nfsa_pkg::MODE_RELEASE, 8'd2, 0);
      repeat (2) send_request(nfsa_pkg::MODE_ALLOC, 8'd0, 0);

      // Lowered count: filling to full, indexes past the count.
      write_slot_count(4);
      repeat (3) send_request(nfsa_pkg::MODE_ALLOC, 8'd0, 0);
      send_request(nfsa_pkg::MODE_RELEASE, 8'd4, 0);
      send_request(nfsa_pkg::MODE_RELEASE, 8'd200, 0);
      send_request(nfsa_pkg::MODE_RELEASE, 8'd3, 0);
      send_request(nfsa_pkg::MODE_ALLOC, 8'd0, 0);

      // Zero count refuses everything.
      write_slot_count(0);
      send_request(nfsa_pkg::MODE_ALLOC, 8'd0, 0);
      send_request(nfsa_pkg::MODE_RELEASE, 8'd0, 0);

      // Counts above the map size are clamped to it.
      write_slot_count(300);
      send_request(nfsa_pkg::MODE_ALLOC, 8'd0, 0);
      write_slot_count(511);
      send_request(nfsa_pkg::MODE_RELEASE, 8'd255, 0);
      write_slot_count(1);
      send_request(nfsa_pkg::MODE_RELEASE, 8'd0, 0);

      run_phase(256, 300, 0);
      run_phase(511, 150, 84);
      run_phase(33, 80, 32);
      run_phase(1, 30, 0);
      run_phase(64, 100, 84);
      run_phase(2, 40, 32);
      run_phase(0, 20, 0);
      run_phase(200, 80, 32);
      run_phase(17, 60, 84);

      drain();
      if (pool_model.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
